[design/rfce_pkg.sv]
// Shared types and constants for the rectangle fill blitter.
// Canvas geometry, command word, operation codes and sequencer states.
// No dependencies; every other design file refers to this package.
`default_nettype none

package rfce_pkg;

	// Canvas geometry
	localparam int CANVAS_WIDTH  = 128;
	localparam int CANVAS_HEIGHT = 128;
	localparam int PIXEL_COUNT   = CANVAS_WIDTH * CANVAS_HEIGHT;
	localparam int ADDR_W        = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

	// Coordinate counters hold the canvas size itself (exclusive ends)
	localparam int XC_W = $clog2(CANVAS_WIDTH + 1);
	localparam int YC_W = $clog2(CANVAS_HEIGHT + 1);

	// Field widths of the stream words
	localparam int POS_W  = 7;
	localparam int SIZE_W = 8;
	localparam int CHAN_W = 8;
	localparam int PIX_W  = 3 * CHAN_W;
	localparam int EXT_W  = 7;

	// Width for clipping arithmetic: corner plus size, and the canvas size
	localparam int SUM_W  = SIZE_W + 1;
	localparam int CMP_W0 = (XC_W > YC_W) ? XC_W : YC_W;
	localparam int CMP_W  = (CMP_W0 > SUM_W) ? CMP_W0 : SUM_W;

	// Row stride, one bit wider so that a single-row canvas still fits
	localparam logic [ADDR_W:0] ROW_STEP = (ADDR_W + 1)'(CANVAS_WIDTH);

	localparam logic [PIX_W-1:0] WHITE = {PIX_W{1'b1}};

	// Stream word widths
	localparam int IN_TDATA_W  = 56;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 40;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_FILL   = 2'd0,
		OP_EXTENT = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// Classified command: clipped rectangle, start address, colour
	typedef struct packed {
		op_t               op;
		logic              skip;
		logic [XC_W-1:0]   x0;
		logic [XC_W-1:0]   x1;
		logic [YC_W-1:0]   y0;
		logic [YC_W-1:0]   y1;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  color;
	} cmd_t;

	// Queue head offered to the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	// Back end status returned to the front
	typedef struct packed {
		logic pop;
		logic init_done;
	} eng_status_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_FILL,
		ST_SCAN,
		ST_SCAN_END,
		ST_READ,
		ST_READ_OUT,
		ST_CLEAR
	} eng_state_t;

endpackage

`default_nettype wire

[design/rfce_front.sv]
// Front end of the blitter: takes input words, clips and classifies them.
// Holds a short command queue for the back end; uses rfce_pkg.
`default_nettype none

module rfce_front (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [rfce_pkg::IN_TDATA_W-1:0]      in_data,
	input  wire  [rfce_pkg::IN_TUSER_W-1:0]      in_user,
	output rfce_pkg::q_head_t                    head,
	input  rfce_pkg::eng_status_t                status
);

	logic [rfce_pkg::POS_W-1:0]  pos_x;
	logic [rfce_pkg::POS_W-1:0]  pos_y;
	logic [rfce_pkg::SIZE_W-1:0] size_x;
	logic [rfce_pkg::SIZE_W-1:0] size_y;
	logic [rfce_pkg::PIX_W-1:0]  color;
	rfce_pkg::op_t               op;

	logic [rfce_pkg::CMP_W-1:0]    sum_x, sum_y, end_x, end_y;
	logic                          fill_empty, outside;
	logic [rfce_pkg::ADDR_W:0]     lin_addr;
	rfce_pkg::cmd_t                cmd;

	rfce_pkg::cmd_t                 queue_q [rfce_pkg::QUEUE_DEPTH];
	logic [rfce_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [rfce_pkg::QCNT_W-1:0]    count_q;
	logic                           push;

	// Unpack the word
	assign op     = rfce_pkg::op_t'(in_user[1:0]);
	assign pos_x  = in_data[6:0];
	assign pos_y  = in_data[13:7];
	assign size_x = in_data[21:14];
	assign size_y = in_data[29:22];
	assign color  = {in_data[37:30], in_data[45:38], in_data[53:46]};

	// Clip the rectangle at the canvas edge
	always_comb begin
		sum_x = rfce_pkg::CMP_W'(pos_x) + rfce_pkg::CMP_W'(size_x);
		sum_y = rfce_pkg::CMP_W'(pos_y) + rfce_pkg::CMP_W'(size_y);
		end_x = (sum_x > rfce_pkg::CMP_W'(rfce_pkg::CANVAS_WIDTH)) ?
			rfce_pkg::CMP_W'(rfce_pkg::CANVAS_WIDTH) : sum_x;
		end_y = (sum_y > rfce_pkg::CMP_W'(rfce_pkg::CANVAS_HEIGHT)) ?
			rfce_pkg::CMP_W'(rfce_pkg::CANVAS_HEIGHT) : sum_y;
		fill_empty = (end_x <= rfce_pkg::CMP_W'(pos_x)) ||
			(end_y <= rfce_pkg::CMP_W'(pos_y));
		outside = (rfce_pkg::CMP_W'(pos_x) >= rfce_pkg::CMP_W'(rfce_pkg::CANVAS_WIDTH)) ||
			(rfce_pkg::CMP_W'(pos_y) >= rfce_pkg::CMP_W'(rfce_pkg::CANVAS_HEIGHT));
		// Linear address of the corner or of the pixel read
		lin_addr = (rfce_pkg::ADDR_W + 1)'(pos_y) * rfce_pkg::ROW_STEP
			+ (rfce_pkg::ADDR_W + 1)'(pos_x);
	end

	// Build the command
	always_comb begin
		cmd.op    = op;
		cmd.x0    = rfce_pkg::XC_W'(pos_x);
		cmd.x1    = rfce_pkg::XC_W'(end_x);
		cmd.y0    = rfce_pkg::YC_W'(pos_y);
		cmd.y1    = rfce_pkg::YC_W'(end_y);
		cmd.addr  = lin_addr[rfce_pkg::ADDR_W-1:0];
		cmd.color = color;
		case (op)
			rfce_pkg::OP_FILL: cmd.skip = fill_empty;
			rfce_pkg::OP_READ: cmd.skip = outside;
			default:           cmd.skip = 1'b0;
		endcase
	end

	// Queue control
	assign in_ready   = status.init_done &&
		(count_q != rfce_pkg::QCNT_W'(rfce_pkg::QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign head.valid = (count_q != '0);
	assign head.cmd   = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == rfce_pkg::QPTR_W'(rfce_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + rfce_pkg::QPTR_W'(1);
			end
			if (status.pop) begin
				rd_ptr_q <= (rd_ptr_q == rfce_pkg::QPTR_W'(rfce_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + rfce_pkg::QPTR_W'(1);
			end
			if (push && !status.pop) begin
				count_q <= count_q + rfce_pkg::QCNT_W'(1);
			end else if (!push && status.pop) begin
				count_q <= count_q - rfce_pkg::QCNT_W'(1);
			end
		end
	end

	// Store the command word
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rfce_pkg::QCNT_W'(rfce_pkg::QUEUE_DEPTH))
		else $error("command queue overfilled");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		status.pop |-> head.valid)
		else $error("pop from empty command queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !status.pop) |=> count_q == $past(count_q) + rfce_pkg::QCNT_W'(1))
		else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

[design/rfce_engine.sv]
// Back end of the blitter: canvas memory and the pixel sequencer.
// Carries out fill, extent scan, read and clear; uses rfce_pkg.
`default_nettype none

module rfce_engine (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  rfce_pkg::q_head_t                   head,
	output rfce_pkg::eng_status_t               status,
	output logic                                res_valid,
	input  wire                                 res_ready,
	output logic [rfce_pkg::PIX_W-1:0]          res_pix,
	output logic [rfce_pkg::EXT_W-1:0]          res_mcol,
	output logic [rfce_pkg::EXT_W-1:0]          res_mrow
);

	rfce_pkg::eng_state_t         state_q, state_nxt;
	rfce_pkg::cmd_t               cmd_q;
	logic [rfce_pkg::ADDR_W-1:0]  addr_q, rowaddr_q;
	logic [rfce_pkg::XC_W-1:0]    x_q, x_s1, mcol_q, mcol_nxt;
	logic [rfce_pkg::YC_W-1:0]    y_q, y_s1, mrow_q, mrow_nxt;
	logic                         scan_vld_s1, hit;
	logic [rfce_pkg::ADDR_W:0]    next_row;

	logic [rfce_pkg::PIX_W-1:0]   canvas_mem [rfce_pkg::PIXEL_COUNT];
	logic [rfce_pkg::PIX_W-1:0]   rd_data_q;
	logic                         mem_we;
	logic [rfce_pkg::PIX_W-1:0]   mem_wdata;

	logic                         res_valid_q, res_set, slot_free, pop;
	logic                         fill_row_end, fill_last, sweep_last;
	logic [rfce_pkg::PIX_W-1:0]   res_pix_q, set_pix;
	logic [rfce_pkg::EXT_W-1:0]   res_mcol_q, res_mrow_q, set_mcol, set_mrow;

	assign slot_free    = !res_valid_q || res_ready;
	assign fill_row_end = (x_q + rfce_pkg::XC_W'(1)) == cmd_q.x1;
	assign fill_last    = fill_row_end && ((y_q + rfce_pkg::YC_W'(1)) == cmd_q.y1);
	assign sweep_last   = addr_q == rfce_pkg::ADDR_W'(rfce_pkg::PIXEL_COUNT - 1);
	assign next_row     = (rfce_pkg::ADDR_W + 1)'(rowaddr_q) + rfce_pkg::ROW_STEP;

	// Fold the pixel read back during a scan into the running extent
	always_comb begin
		hit      = scan_vld_s1 && (rd_data_q != rfce_pkg::WHITE);
		mcol_nxt = (hit && (x_s1 > mcol_q)) ? x_s1 : mcol_q;
		mrow_nxt = hit ? y_s1 : mrow_q;
	end

	// Next state and per-cycle actions
	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = rfce_pkg::WHITE;
		res_set   = 1'b0;
		set_pix   = '0;
		set_mcol  = '0;
		set_mrow  = '0;
		case (state_q)
			rfce_pkg::ST_INIT: begin
				mem_we = 1'b1;
				if (sweep_last) state_nxt = rfce_pkg::ST_IDLE;
			end
			rfce_pkg::ST_IDLE: begin
				if (head.valid && slot_free) begin
					pop = 1'b1;
					case (head.cmd.op)
						rfce_pkg::OP_FILL: begin
							if (head.cmd.skip) res_set = 1'b1;
							else state_nxt = rfce_pkg::ST_FILL;
						end
						rfce_pkg::OP_EXTENT: state_nxt = rfce_pkg::ST_SCAN;
						rfce_pkg::OP_READ: begin
							if (head.cmd.skip) begin
								res_set = 1'b1;
								set_pix = rfce_pkg::WHITE;
							end else begin
								state_nxt = rfce_pkg::ST_READ;
							end
						end
						rfce_pkg::OP_CLEAR: state_nxt = rfce_pkg::ST_CLEAR;
						default: state_nxt = rfce_pkg::ST_IDLE;
					endcase
				end
			end
			rfce_pkg::ST_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = cmd_q.color;
				if (fill_last) begin
					res_set   = 1'b1;
					state_nxt = rfce_pkg::ST_IDLE;
				end
			end
			rfce_pkg::ST_SCAN: begin
				if (sweep_last) state_nxt = rfce_pkg::ST_SCAN_END;
			end
			rfce_pkg::ST_SCAN_END: begin
				res_set   = 1'b1;
				set_mcol  = rfce_pkg::EXT_W'(mcol_nxt);
				set_mrow  = rfce_pkg::EXT_W'(mrow_nxt);
				state_nxt = rfce_pkg::ST_IDLE;
			end
			rfce_pkg::ST_READ: state_nxt = rfce_pkg::ST_READ_OUT;
			rfce_pkg::ST_READ_OUT: begin
				res_set   = 1'b1;
				set_pix   = rd_data_q;
				state_nxt = rfce_pkg::ST_IDLE;
			end
			rfce_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				if (sweep_last) begin
					res_set   = 1'b1;
					state_nxt = rfce_pkg::ST_IDLE;
				end
			end
			default: state_nxt = rfce_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rfce_pkg::ST_INIT;
		else         state_q <= state_nxt;
	end

	// Address and coordinate counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			rowaddr_q   <= '0;
			x_q         <= '0;
			y_q         <= '0;
			mcol_q      <= '0;
			mrow_q      <= '0;
			scan_vld_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			scan_vld_s1 <= (state_q == rfce_pkg::ST_SCAN);
			mcol_q      <= pop ? '0 : mcol_nxt;
			mrow_q      <= pop ? '0 : mrow_nxt;
			case (state_q)
				rfce_pkg::ST_INIT, rfce_pkg::ST_CLEAR: begin
					addr_q <= addr_q + rfce_pkg::ADDR_W'(1);
				end
				rfce_pkg::ST_SCAN: begin
					addr_q <= addr_q + rfce_pkg::ADDR_W'(1);
					if (x_q == rfce_pkg::XC_W'(rfce_pkg::CANVAS_WIDTH - 1)) begin
						x_q <= '0;
						y_q <= y_q + rfce_pkg::YC_W'(1);
					end else begin
						x_q <= x_q + rfce_pkg::XC_W'(1);
					end
				end
				rfce_pkg::ST_IDLE: begin
					if (pop) begin
						if (head.cmd.op == rfce_pkg::OP_FILL ||
							head.cmd.op == rfce_pkg::OP_READ) begin
							addr_q <= head.cmd.addr;
							x_q    <= head.cmd.x0;
							y_q    <= head.cmd.y0;
						end else begin
							addr_q <= '0;
							x_q    <= '0;
							y_q    <= '0;
						end
						rowaddr_q <= head.cmd.addr;
					end
				end
				rfce_pkg::ST_FILL: begin
					if (fill_row_end) begin
						x_q       <= cmd_q.x0;
						y_q       <= y_q + rfce_pkg::YC_W'(1);
						rowaddr_q <= next_row[rfce_pkg::ADDR_W-1:0];
						addr_q    <= next_row[rfce_pkg::ADDR_W-1:0];
					end else begin
						x_q    <= x_q + rfce_pkg::XC_W'(1);
						addr_q <= addr_q + rfce_pkg::ADDR_W'(1);
					end
				end
				default: begin
					addr_q <= addr_q;
				end
			endcase
			// Result register: set on completion, drop when taken
			if (res_set)        res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (pop) cmd_q <= head.cmd;
		x_s1 <= x_q;
		y_s1 <= y_q;
		if (res_set) begin
			res_pix_q  <= set_pix;
			res_mcol_q <= set_mcol;
			res_mrow_q <= set_mrow;
		end
	end

	// Canvas memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) canvas_mem[addr_q] <= mem_wdata;
		rd_data_q <= canvas_mem[addr_q];
	end

	assign status.pop       = pop;
	assign status.init_done = (state_q != rfce_pkg::ST_INIT);
	assign res_valid        = res_valid_q;
	assign res_pix          = res_pix_q;
	assign res_mcol         = res_mcol_q;
	assign res_mrow         = res_mrow_q;

`ifndef SYNTH
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == rfce_pkg::ST_IDLE) && slot_free)
		else $error("command taken while busy or result slot full");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == rfce_pkg::ST_FILL || state_q == rfce_pkg::ST_CLEAR ||
			state_q == rfce_pkg::ST_INIT))
		else $error("canvas written outside a painting state");

	a_init_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status.init_done |=> status.init_done)
		else $error("initial clearing pass restarted");

	a_scan_align: assert property (@(posedge clk) disable iff (!arst_n)
		scan_vld_s1 |-> (state_q == rfce_pkg::ST_SCAN || state_q == rfce_pkg::ST_SCAN_END))
		else $error("scan read data outside a scan");
`endif

endmodule

`default_nettype wire

[design/rect_fill_canvas_extent.sv]
// Top level of the rectangle fill blitter over a 24-bit RGB canvas.
// Joins the classifying front end and the canvas engine; uses rfce_pkg.
//
//   channel   dir  accept on                      payload
//   s_axis    in   s_axis_tvalid & s_axis_tready   tuser: op; tdata: corner, size, colour
//   m_axis    out  m_axis_tvalid & m_axis_tready   tdata: pixel, max column, max row
//
// After reset the canvas is painted white, pixel by pixel, with s_axis_tready low.
// A fill writes one clipped pixel per cycle; an extent query reads and a clear writes
// every pixel; a read takes its pixel from the canvas memory's registered read port,
// beside its one write port. Two commands queue ahead of the engine; a result waits
// in its own register, and the next command starts once that register is free or taken.
`default_nettype none

module rect_fill_canvas_extent (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [6:0] pos_x, [13:7] pos_y, [21:14] size_x, [29:22] size_y,
	// [37:30] fill_red, [45:38] fill_green, [53:46] fill_blue, [55:54] zero
	input  wire  [rfce_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	// [1:0] op
	input  wire  [rfce_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	// [7:0] pix_red, [15:8] pix_green, [23:16] pix_blue,
	// [30:24] max_column, [37:31] max_row, [39:38] zero
	output logic [rfce_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

	rfce_pkg::q_head_t             head;
	rfce_pkg::eng_status_t         status;
	logic [rfce_pkg::PIX_W-1:0]    res_pix;
	logic [rfce_pkg::EXT_W-1:0]    res_mcol, res_mrow;

	rfce_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.head     (head),
		.status   (status)
	);

	rfce_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.status    (status),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_pix   (res_pix),
		.res_mcol  (res_mcol),
		.res_mrow  (res_mrow)
	);

	// Pack the result word, red lowest
	assign m_axis_tdata = {2'b00, res_mrow, res_mcol,
		res_pix[7:0], res_pix[15:8], res_pix[23:16]};

endmodule

`default_nettype wire

[dv/tb_rect_fill_canvas_extent.sv]
// Self-checking bench for rect_fill_canvas_extent: directed table, then random blits.
// Keeps its own copy of the canvas to predict each result word; depends on rfce_pkg.
`timescale 1ns / 1ps

module tb_rect_fill_canvas_extent;
	import rfce_pkg::*;

	localparam int N_DIRECTED   = 24;
	localparam int N_RANDOM     = 76;
	localparam int N_ITEMS      = N_DIRECTED + N_RANDOM;
	localparam int MAX_REPORTS  = 10;
	localparam int DRAIN_CYCLES = 100;
	// Every command as slow as a full canvas walk, plus the clearing pass, several times over
	localparam longint CYCLE_LIMIT = longint'(N_ITEMS + 1) * (PIXEL_COUNT + 64) * 4;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [EXT_W-1:0] max_col;
		logic [EXT_W-1:0] max_row;
	} blit_result_t;

	typedef struct packed {
		op_t               op;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [SIZE_W-1:0] size_x;
		logic [SIZE_W-1:0] size_y;
		logic [PIX_W-1:0]  color;
		logic              has_want;
		blit_result_t      want;
	} blit_cmd_t;

	// op, x, y, width, height, colour, typed result, result (rgb, max column, max row)
	localparam blit_cmd_t DIRECTED_ROWS [N_DIRECTED] = '{
		// untouched canvas
		'{OP_EXTENT, 7'd0,   7'd0,   8'd0,   8'd0,   24'h000000, 1'b1, '{24'h000000, 7'd0,   7'd0}},
		'{OP_READ,   7'd0,   7'd0,   8'd0,   8'd0,   24'h000000, 1'b1, '{WHITE,       7'd0,   7'd0}},
		'{OP_READ,   7'd127, 7'd127, 8'd0,   8'd0,   24'h000000, 1'b1, '{WHITE,       7'd0,   7'd0}},
		// empty rectangles paint nothing
		'{OP_FILL,   7'd0,   7'd0,   8'd0,   8'd0,   24'h000000, 1'b1, '{24'h000000, 7'd0,   7'd0}},
		'{OP_FILL,   7'd64,  7'd64,  8'd0,   8'd9,   24'h000000, 1'b1, '{24'h000000, 7'd0,   7'd0}},
		'{OP_EXTENT, 7'd0,   7'd0,   8'd0,   8'd0,   24'h000000, 1'b1, '{24'h000000, 7'd0,   7'd0}},
		// far corner, clipped to a single pixel
		'{OP_FILL,   7'd127, 7'd127, 8'd128, 8'd128, 24'h123456, 1'b1, '{24'h000000, 7'd0,   7'd0}},
		'{OP_READ,   7'd127, 7'd127, 8'd0,   8'd0,   24'h000000, 1'b1, '{24'h123456, 7'd0,   7'd0}},
		'{OP_EXTENT, 7'd0,   7'd0,   8'd0,   8'd0,   24'h000000, 1'b1, '{24'h000000, 7'd127, 7'd127}},
		// white paint stays white
		'{OP_FILL,   7'd5,   7'd9,   8'd1,   8'd1,   WHITE,      1'b1, '{24'h000000, 7'd0,   7'd0}},
		'{OP_READ,   7'd5,   7'd9,   8'd0,   8'd0,   24'h000000, 1'b1, '{WHITE,       7'd0,   7'd0}},
		'{OP_CLEAR,  7'd0,   7'd0,   8'd0,   8'd0,   24'h000000, 1'b1, '{24'h000000, 7'd0,   7'd0}},
		'{OP_EXTENT, 7'd0,   7'd0,   8'd0,   8'd0,   24'h000000, 1'b1, '{24'h000000, 7'd0,   7'd0}},
		// whole canvas black, then whole canvas white
		'{OP_FILL,   7'd0,   7'd0,   8'd128, 8'd128, 24'h000000, 1'b1, '{24'h000000, 7'd0,   7'd0}},
		'{OP_READ,   7'd64,  7'd3,   8'd0,   8'd0,   24'h000000, 1'b1, '{24'h000000, 7'd0,   7'd0}},
		'{OP_EXTENT, 7'd0,   7'd0,   8'd0,   8'd0,   24'h000000, 1'b1, '{24'h000000, 7'd127, 7'd127}},
		'{OP_FILL,   7'd0,   7'd0,   8'd128, 8'd128, WHITE,      1'b1, '{24'h000000, 7'd0,   7'd0}},
		'{OP_EXTENT, 7'd0,   7'd0,   8'd0,   8'd0,   24'h000000, 1'b1, '{24'h000000, 7'd0,   7'd0}},
		// small shapes, one clipped at the right edge
		'{OP_FILL,   7'd3,   7'd100, 8'd5,   8'd2,   24'hAA55C3, 1'b0, '0},
		'{OP_FILL,   7'd100, 7'd7,   8'd40,  8'd1,   24'h5AA53C, 1'b0, '0},
		'{OP_EXTENT, 7'd0,   7'd0,   8'd0,   8'd0,   24'h000000, 1'b0, '0},
		'{OP_READ,   7'd127, 7'd7,   8'd0,   8'd0,   24'h000000, 1'b0, '0},
		'{OP_READ,   7'd7,   7'd101, 8'd0,   8'd0,   24'h000000, 1'b0, '0},
		'{OP_CLEAR,  7'd0,   7'd0,   8'd0,   8'd0,   24'h000000, 1'b1, '{24'h000000, 7'd0,   7'd0}}
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [IN_TUSER_W-1:0]  s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// Predicted canvas and the result words still owed by the block
	logic [PIX_W-1:0] canvas_px [PIXEL_COUNT];
	blit_result_t     pending_results [$];

	int     src_idle_pct = 34;
	int     snk_idle_pct = 88;
	int     mismatch_cnt = 0;
	int     results_seen = 0;
	int     words_sent   = 0;
	int     op_count [4] = '{0, 0, 0, 0};
	longint cycle_cnt    = 0;

	// Last painted rectangle, clipped, so that reads land on paint
	int  last_x0, last_x1, last_y0, last_y1;
	bit  rect_live = 1'b0;

	rect_fill_canvas_extent i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Apply one command to the predicted canvas and return the word it yields
	function automatic blit_result_t canvas_step(input blit_cmd_t c);
		blit_result_t r;
		int x, y, x_end, y_end, col_hi, row_hi;
		r      = '0;
		col_hi = 0;
		row_hi = 0;
		case (c.op)
			OP_FILL: begin
				x_end = int'(c.pos_x) + int'(c.size_x);
				y_end = int'(c.pos_y) + int'(c.size_y);
				if (x_end > CANVAS_WIDTH) x_end = CANVAS_WIDTH;
				if (y_end > CANVAS_HEIGHT) y_end = CANVAS_HEIGHT;
				for (y = int'(c.pos_y); y < y_end; y++)
					for (x = int'(c.pos_x); x < x_end; x++)
						canvas_px[y * CANVAS_WIDTH + x] = c.color;
			end
			OP_EXTENT: begin
				for (y = 0; y < CANVAS_HEIGHT; y++)
					for (x = 0; x < CANVAS_WIDTH; x++)
						if (canvas_px[y * CANVAS_WIDTH + x] != WHITE) begin
							if (x > col_hi) col_hi = x;
							if (y > row_hi) row_hi = y;
						end
				r.max_col = EXT_W'(col_hi);
				r.max_row = EXT_W'(row_hi);
			end
			OP_READ: begin
				if (int'(c.pos_x) < CANVAS_WIDTH && int'(c.pos_y) < CANVAS_HEIGHT)
					r.pix = canvas_px[int'(c.pos_y) * CANVAS_WIDTH + int'(c.pos_x)];
				else
					r.pix = WHITE;
			end
			OP_CLEAR: begin
				foreach (canvas_px[i]) canvas_px[i] = WHITE;
			end
		endcase
		return r;
	endfunction

	// Mostly fills and reads that hit recent paint; extent queries and clears kept rare
	function automatic blit_cmd_t random_blit();
		blit_cmd_t c;
		int pick;
		c    = '0;
		pick = $urandom_range(99);
		if (pick < 50) begin
			c.op    = OP_FILL;
			c.pos_x = POS_W'($urandom_range(127));
			c.pos_y = POS_W'($urandom_range(127));
			if ($urandom_range(9) == 0) begin
				c.size_x = SIZE_W'($urandom_range(128));
				c.size_y = SIZE_W'($urandom_range(128));
			end else begin
				c.size_x = SIZE_W'($urandom_range(16));
				c.size_y = SIZE_W'($urandom_range(16));
			end
			c.color = ($urandom_range(7) == 0) ? WHITE : PIX_W'($urandom);
			last_x0 = int'(c.pos_x);
			last_y0 = int'(c.pos_y);
			last_x1 = last_x0 + int'(c.size_x);
			last_y1 = last_y0 + int'(c.size_y);
			if (last_x1 > CANVAS_WIDTH) last_x1 = CANVAS_WIDTH;
			if (last_y1 > CANVAS_HEIGHT) last_y1 = CANVAS_HEIGHT;
			rect_live = (last_x1 > last_x0) && (last_y1 > last_y0);
		end else if (pick < 88) begin
			c.op = OP_READ;
			if (rect_live && $urandom_range(3) != 0) begin
				c.pos_x = POS_W'($urandom_range(last_x1 - 1, last_x0));
				c.pos_y = POS_W'($urandom_range(last_y1 - 1, last_y0));
			end else begin
				c.pos_x = POS_W'($urandom_range(127));
				c.pos_y = POS_W'($urandom_range(127));
			end
		end else if (pick < 94) begin
			c.op = OP_EXTENT;
		end else begin
			c.op = OP_CLEAR;
		end
		return c;
	endfunction

	// Offer one word, hold it until taken, then record the expected result
	task automatic push_word(input blit_cmd_t c);
		blit_result_t want;
		int phase;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= c.op;
		s_axis_tdata  <= {2'b00, c.color[7:0], c.color[15:8], c.color[23:16],
			c.size_y, c.size_x, c.pos_y, c.pos_x};
		do @(posedge clk); while (!s_axis_tready);
		want = canvas_step(c);
		if (c.has_want)
			want = c.want;
		pending_results.push_back(want);
		op_count[c.op]++;
		words_sent++;
		// Idle mix moves on by thirds of the run
		phase = words_sent * 3 / N_ITEMS;
		if (phase == 0) begin
			src_idle_pct = 34;
			snk_idle_pct = 88;
		end else if (phase == 1) begin
			src_idle_pct = 88;
			snk_idle_pct = 34;
		end else begin
			src_idle_pct = 0;
			snk_idle_pct = 0;
		end
		@(negedge clk);
	endtask

	// Receiver back-pressure
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);

	// Compare each result word with the oldest prediction
	always @(posedge clk) begin : check_results
		blit_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.pix     = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]};
			got.max_col = m_axis_tdata[30:24];
			got.max_row = m_axis_tdata[37:31];
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("result word %0d with nothing expected: rgb=%06h col=%0d row=%0d",
						results_seen, got.pix, got.max_col, got.max_row);
			end else begin
				want = pending_results.pop_front();
				if (got.pix != want.pix || got.max_col != want.max_col
						|| got.max_row != want.max_row) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("word %0d: want %06h/%0d/%0d, got %06h/%0d/%0d",
							results_seen, want.pix, want.max_col, want.max_row,
							got.pix, got.max_col, got.max_row);
				end
			end
		end
	end

	// Drop out if the block hangs
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still expected",
				cycle_cnt, pending_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_FILL;
		foreach (canvas_px[i]) canvas_px[i] = WHITE;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			push_word(DIRECTED_ROWS[i]);
		for (int i = 0; i < N_RANDOM; i++)
			push_word(random_blit());
		s_axis_tvalid <= 1'b0;

		// Wait for the last result, then watch for stray words
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d fills, %0d extent queries, %0d pixel reads and %0d clears",
			op_count[OP_FILL], op_count[OP_EXTENT], op_count[OP_READ], op_count[OP_CLEAR]);
		$display("Checked %0d result words in %0d cycles, %0d mismatching",
			results_seen, cycle_cnt, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[files.f]
design/rfce_pkg.sv
design/rfce_front.sv
design/rfce_engine.sv
design/rect_fill_canvas_extent.sv
dv/tb_rect_fill_canvas_extent.sv
